### rtl/tvp_pkg.sv
// Shared types and constants of the trapezoidal velocity profile generator.
package tvp_pkg;

   localparam int CSR_INDEX_W = 2;

   localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
   localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
   localparam logic [1:0] REG_TIME_STEP        = 2'd2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [30:0] TIME_CAP    = 31'h7FFF_FFFF;
   localparam logic [30:0] RST_MAX_VEL = 31'd65536;
   localparam logic [30:0] RST_MAX_ACC = 31'd65536;
   localparam logic [30:0] RST_STEP    = 31'd655;

   localparam logic [5:0] DIV_STEPS  = 6'd48;
   localparam logic [5:0] SQRT_STEPS = 6'd32;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RT_GO,
      ST_RT_WAIT,
      ST_RD_MUL1,
      ST_RD_MUL2,
      ST_RD_DONE,
      ST_TX_GO,
      ST_TX_WAIT,
      ST_SQ_WAIT,
      ST_PK_MUL,
      ST_PK_DONE,
      ST_CT_GO,
      ST_CT_WAIT,
      ST_TK_MUL1,
      ST_TK_MUL2,
      ST_TK_MUL3,
      ST_TK_MUL4,
      ST_TK_OUT
   } tvp_state_type;

   typedef enum logic [1:0] {
      PH_ACCEL,
      PH_CRUISE,
      PH_DECEL
   } tvp_phase_type;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } tvp_ds_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } tvp_ds_stat_type;

endpackage

### rtl/tvp_if.sv
// Handshake channel interfaces of the trapezoidal velocity profile generator.
interface tvp_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] start_position;
   logic signed [31:0] end_position;
   modport source (output valid, command, start_position, end_position, input ready);
   modport sink   (input valid, command, start_position, end_position, output ready);
endinterface

interface tvp_rsp_if;
   logic               valid;
   logic               ready;
   logic        [30:0] sample_time;
   logic signed [31:0] position;
   logic signed [31:0] velocity;
   logic signed [31:0] acceleration;
   logic               last_point;
   modport source (output valid, sample_time, position, velocity, acceleration, last_point,
                   input ready);
   modport sink   (input valid, sample_time, position, velocity, acceleration, last_point,
                   output ready);
endinterface

interface tvp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tvp_pkg::CSR_INDEX_W-1:0] index;
   logic [30:0]                     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/trapezoidal_velocity_profile_top.sv
// Top level of the single-axis trapezoidal velocity profile generator.
// A start word (command 0) latches the start position in signed Q16.16 with the direction and
// distance of the move and plans it: ramp time, ramp distance, cruise time, total time and peak
// velocity, falling back to a triangle profile when the move is too short to reach full speed.
// Planning runs through one bit-serial divide and square-root unit that yields one quotient bit
// or one root bit per cycle, and no new word is taken while planning runs. Each tick word
// (command 1) then yields one point from up to three products through the single registered
// multiplier. Ticks while no move is active give no result, and a start word gives none either.
// The result register lets the next word be taken while a point still waits on the result
// channel; only a tick's final cycle waits for it.
// Configuration writes are always accepted and are meant to happen only while the block is idle.
module trapezoidal_velocity_profile_top (
   input  logic      clock,
   input  logic      reset,
   tvp_req_if.sink   req_ch,
   tvp_rsp_if.source rsp_ch,
   tvp_csr_if.sink   csr_ch
);

   // Configuration registers.
   logic [30:0] max_vel_ff, max_vel_in;
   logic [30:0] max_acc_ff, max_acc_in;
   logic [30:0] step_ff,    step_in;

   // Move state.
   tvp_pkg::tvp_state_type state_ff, state_in;
   tvp_pkg::tvp_phase_type phase_ff, phase_in;
   logic signed [31:0] origin_ff, origin_in;
   logic               neg_ff,    neg_in;
   logic [31:0]        dist_ff,   dist_in;
   logic [30:0]        rt_ff,     rt_in;
   logic [30:0]        rd_ff,     rd_in;
   logic [30:0]        ct_ff,     ct_in;
   logic [30:0]        total_ff,  total_in;
   logic [30:0]        pv_ff,     pv_in;
   logic [30:0]        t_ff,      t_in;
   logic               active_ff, active_in;
   logic signed [34:0] pos_ff,    pos_in;
   logic signed [33:0] vel_ff,    vel_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [30:0]        o_time_ff,    o_time_in;
   logic signed [31:0] o_pos_ff,     o_pos_in;
   logic signed [31:0] o_vel_ff,     o_vel_in;
   logic signed [31:0] o_acc_ff,     o_acc_in;
   logic               o_last_ff,    o_last_in;

   // Shared units.
   logic [31:0]              mul_a, mul_b, mul_q;
   tvp_pkg::tvp_ds_ctrl_type ds_ctrl;
   tvp_pkg::tvp_ds_stat_type ds_stat;
   logic [63:0]              ds_operand;
   logic [30:0]              ds_divisor;
   logic [47:0]              ds_result;

   logic                     req_fire;
   logic signed [32:0]       diff_pos;
   logic [31:0]              ramp_cruise;
   tvp_pkg::tvp_phase_type   phase_now;
   logic [30:0]              td;
   logic [30:0]              remain;
   logic [47:0]              tri_x;
   logic [30:0]              sq_rt;
   logic [30:0]              ct_quot;
   logic [31:0]              twice_rt;
   logic [32:0]              sum_total;
   logic [31:0]              next_t;
   logic                     last_now;
   logic                     out_free;
   logic signed [34:0]       pos_dir;
   logic signed [33:0]       vel_dir;
   logic signed [31:0]       acc_dir;
   logic signed [35:0]       pos_abs;

   function automatic logic [30:0] cap_quot(input logic [47:0] q, input logic zero_den);
      logic [30:0] r;
      if (zero_den || (|q[47:31])) r = tvp_pkg::TIME_CAP;
      else                         r = q[30:0];
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (v < -36'sd2147483648) r = 32'h8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

   tvp_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .q     (mul_q)
   );

   tvp_divsqrt u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ds_ctrl),
      .operand (ds_operand),
      .divisor (ds_divisor),
      .stat    (ds_stat),
      .result  (ds_result)
   );

   assign req_ch.ready = (state_ff == tvp_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;

   // Helper values for planning and for phase selection.
   assign diff_pos    = {req_ch.end_position[31], req_ch.end_position}
                      - {req_ch.start_position[31], req_ch.start_position};
   assign ramp_cruise = {1'b0, rt_ff} + {1'b0, ct_ff};
   assign td          = 31'({1'b0, t_ff} - ramp_cruise);
   assign remain      = (total_ff > t_ff) ? (total_ff - t_ff) : '0;
   assign tri_x       = (max_acc_ff == '0) ? 48'hFFFF_FFFF_FFFF : ds_result;
   assign sq_rt       = ds_result[31] ? tvp_pkg::TIME_CAP : ds_result[30:0];
   assign ct_quot     = cap_quot(ds_result, max_vel_ff == '0);
   assign twice_rt    = {sq_rt, 1'b0};
   assign sum_total   = {1'b0, rt_ff, 1'b0} + {2'b00, ct_quot};
   assign next_t      = {1'b0, t_ff} + {1'b0, step_ff};
   assign last_now    = next_t > {1'b0, total_ff};

   always_comb begin
      if ({1'b0, t_ff} < {1'b0, rt_ff}) phase_now = tvp_pkg::PH_ACCEL;
      else if ({1'b0, t_ff} < ramp_cruise) phase_now = tvp_pkg::PH_CRUISE;
      else phase_now = tvp_pkg::PH_DECEL;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tvp_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.command == tvp_pkg::CMD_START) state_in = tvp_pkg::ST_RT_GO;
               else if (active_ff)                      state_in = tvp_pkg::ST_TK_MUL1;
            end
         end
         tvp_pkg::ST_RT_GO:   state_in = tvp_pkg::ST_RT_WAIT;
         tvp_pkg::ST_RT_WAIT: if (ds_stat.done) state_in = tvp_pkg::ST_RD_MUL1;
         tvp_pkg::ST_RD_MUL1: state_in = tvp_pkg::ST_RD_MUL2;
         tvp_pkg::ST_RD_MUL2: state_in = tvp_pkg::ST_RD_DONE;
         tvp_pkg::ST_RD_DONE: begin
            if ({mul_q[31:1], 1'b0} > dist_ff) state_in = tvp_pkg::ST_TX_GO;
            else                               state_in = tvp_pkg::ST_CT_GO;
         end
         tvp_pkg::ST_TX_GO:   state_in = tvp_pkg::ST_TX_WAIT;
         tvp_pkg::ST_TX_WAIT: if (ds_stat.done) state_in = tvp_pkg::ST_SQ_WAIT;
         tvp_pkg::ST_SQ_WAIT: if (ds_stat.done) state_in = tvp_pkg::ST_PK_MUL;
         tvp_pkg::ST_PK_MUL:  state_in = tvp_pkg::ST_PK_DONE;
         tvp_pkg::ST_PK_DONE: state_in = tvp_pkg::ST_IDLE;
         tvp_pkg::ST_CT_GO:   state_in = tvp_pkg::ST_CT_WAIT;
         tvp_pkg::ST_CT_WAIT: if (ds_stat.done) state_in = tvp_pkg::ST_IDLE;
         tvp_pkg::ST_TK_MUL1: state_in = tvp_pkg::ST_TK_MUL2;
         tvp_pkg::ST_TK_MUL2: state_in = tvp_pkg::ST_TK_MUL3;
         tvp_pkg::ST_TK_MUL3: state_in = tvp_pkg::ST_TK_MUL4;
         tvp_pkg::ST_TK_MUL4: state_in = tvp_pkg::ST_TK_OUT;
         tvp_pkg::ST_TK_OUT:  if (out_free) state_in = tvp_pkg::ST_IDLE;
         default:             state_in = tvp_pkg::ST_IDLE;
      endcase
   end

   // Operand selection for the shared multiplier and divide/root unit.
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      ds_ctrl    = '0;
      ds_operand = '0;
      ds_divisor = max_acc_ff;
      case (state_ff)
         tvp_pkg::ST_RT_GO: begin
            ds_ctrl.start = 1'b1;
            ds_operand    = {1'b0, max_vel_ff, 32'h0};
         end
         tvp_pkg::ST_RD_MUL1: begin
            mul_a = {1'b0, max_acc_ff};
            mul_b = {1'b0, rt_ff};
         end
         tvp_pkg::ST_RD_MUL2: begin
            mul_a = mul_q;
            mul_b = {1'b0, rt_ff};
         end
         tvp_pkg::ST_TX_GO: begin
            ds_ctrl.start = 1'b1;
            ds_operand    = {dist_ff, 32'h0};
         end
         tvp_pkg::ST_TX_WAIT: begin
            ds_ctrl.start     = ds_stat.done;
            ds_ctrl.sqrt_mode = 1'b1;
            ds_operand        = {tri_x, 16'h0};
         end
         tvp_pkg::ST_PK_MUL: begin
            mul_a = {1'b0, max_acc_ff};
            mul_b = {1'b0, rt_ff};
         end
         tvp_pkg::ST_CT_GO: begin
            ds_ctrl.start = 1'b1;
            ds_operand    = {dist_ff - {rd_ff, 1'b0}, 32'h0};
            ds_divisor    = max_vel_ff;
         end
         tvp_pkg::ST_TK_MUL1: begin
            case (phase_now)
               tvp_pkg::PH_ACCEL: begin
                  mul_a = {1'b0, max_acc_ff};
                  mul_b = {1'b0, t_ff};
               end
               tvp_pkg::PH_CRUISE: begin
                  mul_a = {1'b0, pv_ff};
                  mul_b = {1'b0, t_ff - rt_ff};
               end
               default: begin
                  mul_a = {1'b0, max_acc_ff};
                  mul_b = {1'b0, td};
               end
            endcase
         end
         tvp_pkg::ST_TK_MUL2: begin
            if (phase_ff == tvp_pkg::PH_ACCEL) begin
               mul_a = mul_q;
               mul_b = {1'b0, t_ff};
            end else if (phase_ff == tvp_pkg::PH_DECEL) begin
               mul_a = {1'b0, max_acc_ff};
               mul_b = {1'b0, remain};
            end
         end
         tvp_pkg::ST_TK_MUL3: begin
            mul_a = mul_q;
            mul_b = {1'b0, remain};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      max_vel_in   = max_vel_ff;
      max_acc_in   = max_acc_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      origin_in    = origin_ff;
      neg_in       = neg_ff;
      dist_in      = dist_ff;
      rt_in        = rt_ff;
      rd_in        = rd_ff;
      ct_in        = ct_ff;
      total_in     = total_ff;
      pv_in        = pv_ff;
      t_in         = t_ff;
      active_in    = active_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      o_time_in    = o_time_ff;
      o_pos_in     = o_pos_ff;
      o_vel_in     = o_vel_ff;
      o_acc_in     = o_acc_ff;
      o_last_in    = o_last_ff;
      pos_dir      = neg_ff ? -pos_ff : pos_ff;
      vel_dir      = neg_ff ? -vel_ff : vel_ff;
      pos_abs      = {{4{origin_ff[31]}}, origin_ff} + {pos_dir[34], pos_dir};
      acc_dir      = '0;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            tvp_pkg::REG_MAX_VELOCITY:     max_vel_in = csr_ch.data;
            tvp_pkg::REG_MAX_ACCELERATION: max_acc_in = csr_ch.data;
            tvp_pkg::REG_TIME_STEP:        step_in    = csr_ch.data;
            default:                       step_in    = step_ff;
         endcase
      end

      case (state_ff)
         tvp_pkg::ST_IDLE: begin
            if (req_fire && (req_ch.command == tvp_pkg::CMD_START)) begin
               // A zero distance counts as a negative move.
               origin_in = req_ch.start_position;
               neg_in    = diff_pos[32] | (diff_pos == '0);
               dist_in   = diff_pos[32] ? 32'(-diff_pos) : diff_pos[31:0];
               active_in = 1'b0;
            end
         end
         tvp_pkg::ST_RT_WAIT: begin
            if (ds_stat.done) rt_in = cap_quot(ds_result, max_acc_ff == '0);
         end
         tvp_pkg::ST_RD_DONE: begin
            rd_in = mul_q[31:1];
         end
         tvp_pkg::ST_SQ_WAIT: begin
            // Triangle profile: ramp time from the root, no cruise.
            if (ds_stat.done) begin
               rt_in    = sq_rt;
               ct_in    = '0;
               total_in = twice_rt[31] ? tvp_pkg::TIME_CAP : twice_rt[30:0];
            end
         end
         tvp_pkg::ST_PK_DONE: begin
            pv_in     = mul_q[31] ? tvp_pkg::TIME_CAP : mul_q[30:0];
            t_in      = '0;
            active_in = 1'b1;
         end
         tvp_pkg::ST_CT_WAIT: begin
            if (ds_stat.done) begin
               ct_in     = ct_quot;
               total_in  = (|sum_total[32:31]) ? tvp_pkg::TIME_CAP : sum_total[30:0];
               pv_in     = max_vel_ff;
               t_in      = '0;
               active_in = 1'b1;
            end
         end
         tvp_pkg::ST_TK_MUL1: begin
            phase_in = phase_now;
         end
         tvp_pkg::ST_TK_MUL2: begin
            case (phase_ff)
               tvp_pkg::PH_ACCEL: vel_in = $signed({2'b00, mul_q});
               tvp_pkg::PH_CRUISE: begin
                  vel_in = $signed({3'b000, pv_ff});
                  pos_in = $signed({2'b00, {2'b00, rd_ff} + {1'b0, mul_q}});
               end
               default: vel_in = $signed({3'b000, pv_ff}) - $signed({2'b00, mul_q});
            endcase
         end
         tvp_pkg::ST_TK_MUL3: begin
            if (phase_ff == tvp_pkg::PH_ACCEL) pos_in = $signed({4'b0000, mul_q[31:1]});
         end
         tvp_pkg::ST_TK_MUL4: begin
            if (phase_ff == tvp_pkg::PH_DECEL) begin
               pos_in = $signed({3'b000, dist_ff}) - $signed({4'b0000, mul_q[31:1]});
            end
         end
         tvp_pkg::ST_TK_OUT: begin
            case (phase_ff)
               tvp_pkg::PH_ACCEL:  acc_dir = neg_ff ? -$signed({1'b0, max_acc_ff})
                                                    :  $signed({1'b0, max_acc_ff});
               tvp_pkg::PH_CRUISE: acc_dir = '0;
               default:            acc_dir = neg_ff ?  $signed({1'b0, max_acc_ff})
                                                    : -$signed({1'b0, max_acc_ff});
            endcase
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_time_in    = t_ff;
               o_pos_in     = sat32(pos_abs);
               o_vel_in     = sat32({{2{vel_dir[33]}}, vel_dir});
               o_acc_in     = acc_dir;
               o_last_in    = last_now;
               if (last_now) active_in = 1'b0;
               else          t_in      = next_t[30:0];
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      pos_ff    <= pos_in;
      vel_ff    <= vel_in;
      o_time_ff <= o_time_in;
      o_pos_ff  <= o_pos_in;
      o_vel_ff  <= o_vel_in;
      o_acc_ff  <= o_acc_in;
      o_last_ff <= o_last_in;
      if (reset) begin
         max_vel_ff   <= tvp_pkg::RST_MAX_VEL;
         max_acc_ff   <= tvp_pkg::RST_MAX_ACC;
         step_ff      <= tvp_pkg::RST_STEP;
         state_ff     <= tvp_pkg::ST_IDLE;
         origin_ff    <= '0;
         neg_ff       <= 1'b0;
         dist_ff      <= '0;
         rt_ff        <= '0;
         rd_ff        <= '0;
         ct_ff        <= '0;
         total_ff     <= '0;
         pv_ff        <= '0;
         t_ff         <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_vel_ff   <= max_vel_in;
         max_acc_ff   <= max_acc_in;
         step_ff      <= step_in;
         state_ff     <= state_in;
         origin_ff    <= origin_in;
         neg_ff       <= neg_in;
         dist_ff      <= dist_in;
         rt_ff        <= rt_in;
         rd_ff        <= rd_in;
         ct_ff        <= ct_in;
         total_ff     <= total_in;
         pv_ff        <= pv_in;
         t_ff         <= t_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample_time  = o_time_ff;
   assign rsp_ch.position     = o_pos_ff;
   assign rsp_ch.velocity     = o_vel_ff;
   assign rsp_ch.acceleration = o_acc_ff;
   assign rsp_ch.last_point   = o_last_ff;

`ifndef SYNTHESIS
   // The divide/root unit only runs while the sequencer waits for it.
   a_ds_busy_wait: assert property (@(posedge clock) disable iff (reset)
      ds_stat.busy |-> (state_ff == tvp_pkg::ST_RT_WAIT || state_ff == tvp_pkg::ST_TX_WAIT ||
                        state_ff == tvp_pkg::ST_SQ_WAIT || state_ff == tvp_pkg::ST_CT_WAIT))
      else $error("divide/root unit busy outside a wait state");

   // An active move never runs past its total time.
   a_time_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (t_ff <= total_ff))
      else $error("move time beyond total time");

   // A new point only appears after the output step of a tick.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tvp_pkg::ST_TK_OUT))
      else $error("result raised outside the output step");
`endif

endmodule

### rtl/tvp_mul.sv
// Registered Q16.16 unsigned multiplier with saturation to 32 bits.
module tvp_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] q
);
   logic [63:0] prod;
   logic [31:0] q_ff;
   logic [31:0] q_in;

   assign prod = a * b;
   assign q_in = (|prod[63:48]) ? 32'hFFFF_FFFF : prod[47:16];

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

### rtl/tvp_divsqrt.sv
// Bit-serial restoring divider and digit-by-digit square root sharing one subtractor.
module tvp_divsqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  tvp_pkg::tvp_ds_ctrl_type ctrl,
   input  logic [63:0]              operand,
   input  logic [30:0]              divisor,
   output tvp_pkg::tvp_ds_stat_type stat,
   output logic [47:0]              result
);
   logic [63:0] src_ff,  src_in;
   logic [33:0] acc_ff,  acc_in;
   logic [47:0] res_ff,  res_in;
   logic [30:0] den_ff,  den_in;
   logic [5:0]  cnt_ff,  cnt_in;
   logic        mode_ff, mode_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [35:0] rem_sh;
   logic [35:0] sub_b;
   logic [36:0] diff;
   logic        fits;

   // Divide brings down one dividend bit a step, the root two radicand bits.
   // The root remainder can reach twice the partial root, so the full remainder is kept.
   assign rem_sh = mode_ff ? {acc_ff, src_ff[63:62]} : {1'b0, acc_ff, src_ff[63]};
   assign sub_b  = mode_ff ? {2'b00, res_ff[31:0], 2'b01} : {5'b00000, den_ff};
   assign diff   = {1'b0, rem_sh} - {1'b0, sub_b};
   assign fits   = ~diff[36];

   always_comb begin
      src_in  = src_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         src_in  = operand;
         acc_in  = '0;
         res_in  = '0;
         den_in  = divisor;
         mode_in = ctrl.sqrt_mode;
         cnt_in  = ctrl.sqrt_mode ? tvp_pkg::SQRT_STEPS : tvp_pkg::DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = fits ? diff[33:0] : rem_sh[33:0];
         res_in = {res_ff[46:0], fits};
         src_in = mode_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      den_ff  <= den_in;
      mode_ff <= mode_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;
endmodule

### dv/tb_top.sv
// Self-checking testbench of the trapezoidal velocity profile generator.
`timescale 1ns / 1ps

module tb_top;

   // This index holds no register, so a write to it must change nothing.
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam longint unsigned MUL_CAP = 64'hFFFF_FFFF;
   localparam longint unsigned TCAP = 64'h7FFF_FFFF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam int ITEM_TARGET = 2000;

   typedef struct {
      logic [30:0]        sample_time;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic               last_point;
   } point_type;

   typedef struct {
      logic               command;
      logic signed [31:0] start_pos;
      logic signed [31:0] end_pos;
      bit                 typed;
      point_type          point;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tvp_req_if req_ch();
   tvp_rsp_if rsp_ch();
   tvp_csr_if csr_ch();

   trapezoidal_velocity_profile_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #4 clock = ~clock;

   // Planned profile of the current move, mirrored from what the block should hold.
   longint unsigned lim_vel, lim_acc, step_len;
   longint          home_pos;
   bit              heading_neg;
   longint unsigned travel, accel_span, accel_dist, coast_span, move_span, top_speed, now_t;
   bit              moving;

   point_type points_due[$];
   int        error_count = 0;
   int        points_seen = 0;
   int        quiet_cycles = 0;
   bit        held_off = 1'b0;

   function automatic longint unsigned clip(longint unsigned v, longint unsigned c);
      return (v > c) ? c : v;
   endfunction

   function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
      return clip((clip(a, MUL_CAP) * clip(b, MUL_CAP)) >> 16, MUL_CAP);
   endfunction

   function automatic longint unsigned fix_div(longint unsigned num, longint unsigned den,
                                               longint unsigned c);
      if (den == 0) begin
         return c;
      end
      return clip((num << 16) / den, c);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Plans a new move exactly as a start word should.
   function automatic void plan_move(logic signed [31:0] s, logic signed [31:0] e);
      longint          d;
      longint unsigned x;
      d = longint'(e) - longint'(s);
      home_pos = s;
      heading_neg = !(d > 0);
      travel = (d < 0) ? -d : d;
      accel_span = fix_div(lim_vel, lim_acc, TCAP);
      accel_dist = fix_mul(fix_mul(lim_acc, accel_span), accel_span) >> 1;
      if (2 * accel_dist > travel) begin
         // Too short to reach full speed, so the profile becomes a triangle.
         x = fix_div(travel, lim_acc, 64'd1 << 48);
         if (x >= (64'd1 << 48)) x = (64'd1 << 48) - 1;
         accel_span = clip(root_floor(x << 16), TCAP);
         coast_span = 0;
         move_span = clip(2 * accel_span, TCAP);
         top_speed = clip(fix_mul(lim_acc, accel_span), TCAP);
      end else begin
         coast_span = fix_div(travel - 2 * accel_dist, lim_vel, TCAP);
         move_span = clip(2 * accel_span + coast_span, TCAP);
         top_speed = lim_vel;
      end
      now_t = 0;
      moving = 1'b1;
   endfunction

   // Works out the point of one tick; returns 0 when no move is active.
   function automatic bit next_point(output point_type p);
      longint unsigned t, at, td, r;
      longint          pos, vel, acc, sgn;
      bit              fin;
      if (!moving) return 0;
      t = now_t;
      if (t < accel_span) begin
         at = fix_mul(lim_acc, t);
         acc = lim_acc;
         vel = at;
         pos = fix_mul(at, t) >> 1;
      end else if (t < accel_span + coast_span) begin
         acc = 0;
         vel = top_speed;
         pos = longint'(accel_dist) + longint'(fix_mul(top_speed, t - accel_span));
      end else begin
         td = t - accel_span - coast_span;
         r = (move_span > t) ? move_span - t : 0;
         acc = -longint'(lim_acc);
         vel = longint'(top_speed) - longint'(fix_mul(lim_acc, td));
         pos = longint'(travel) - longint'(fix_mul(fix_mul(lim_acc, r), r) >> 1);
      end
      sgn = heading_neg ? -1 : 1;
      fin = (t + step_len) > move_span;
      p.sample_time = t[30:0];
      p.position = sat_word(home_pos + sgn * pos);
      p.velocity = sat_word(sgn * vel);
      p.acceleration = sat_word(sgn * acc);
      p.last_point = fin;
      if (fin) moving = 1'b0;
      else now_t = t + step_len;
      return 1;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      error_count++;
      $display("mismatch %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
   endtask

   // Idling draws: a quiet stretch may switch gaps off for a while.
   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(3);
   endfunction

   // Sends one word on the request channel; returns after acceptance, at the falling edge.
   task automatic send_word(logic cmd, logic signed [31:0] s, logic signed [31:0] e,
                            bit typed, point_type want, bit quiet);
      int        gap;
      point_type p;
      bit        got;
      gap = draw_gap(quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.start_position <= s;
      req_ch.end_position <= e;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == tvp_pkg::CMD_START) begin
         plan_move(s, e);
      end else begin
         got = next_point(p);
         if (got) begin
            if (typed) points_due.insert(points_due.size(), want);
            else       points_due.insert(points_due.size(), p);
         end
      end
      @(negedge clock);
   endtask

   // Waits until the block has finished every point and any planning left over.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (points_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Leaves valid high; the caller drops it after its last write.
   task automatic write_reg(logic [1:0] idx, logic [30:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         tvp_pkg::REG_MAX_VELOCITY:     lim_vel = value;
         tvp_pkg::REG_MAX_ACCELERATION: lim_acc = value;
         tvp_pkg::REG_TIME_STEP:        step_len = value;
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // Receiver: random hold-offs per word, and one long hold-off so that the block backs up.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int gap;
         gap = $urandom_range(3);
         if (!held_off && points_seen >= 300) begin
            held_off = 1'b1;
            gap = 600;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Checks each point against the oldest one due, and keeps the watchdog.
   always @(posedge clock) begin
      point_type want;
      bit        moved;
      if (!reset) begin
         moved = (req_ch.valid && req_ch.ready) || (csr_ch.valid && csr_ch.ready)
               || (rsp_ch.valid && rsp_ch.ready);
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            points_seen <= points_seen + 1;
            if (points_due.size() == 0) begin
               error_count++;
               $display("unexpected point at %0t", $realtime);
            end else begin
               want = points_due.pop_front();
               if (rsp_ch.sample_time !== want.sample_time)
                  report_mismatch("sample_time", rsp_ch.sample_time, want.sample_time);
               if (rsp_ch.position !== want.position)
                  report_mismatch("position", rsp_ch.position, want.position);
               if (rsp_ch.velocity !== want.velocity)
                  report_mismatch("velocity", rsp_ch.velocity, want.velocity);
               if (rsp_ch.acceleration !== want.acceleration)
                  report_mismatch("acceleration", rsp_ch.acceleration, want.acceleration);
               if (rsp_ch.last_point !== want.last_point)
                  report_mismatch("last_point", rsp_ch.last_point, want.last_point);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Stimulus: a directed table, then random moves under several register settings.
   initial begin
      stim_row_type       rows[$];
      stim_row_type       row;
      point_type          none;
      point_type          zero_move;
      int                 items;
      int                 ticks;
      int                 span_bits;
      bit                 quiet;
      logic signed [31:0] s, e;
      logic [31:0]        mag;

      none = '{default: '0};
      zero_move = '{sample_time: 31'd0, position: 32'sd0, velocity: 32'sd0,
                    acceleration: 32'sd65536, last_point: 1'b1};

      req_ch.valid = 1'b0;
      req_ch.command = tvp_pkg::CMD_TICK;
      req_ch.start_position = '0;
      req_ch.end_position = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = tvp_pkg::REG_MAX_VELOCITY;
      csr_ch.data = '0;
      lim_vel = tvp_pkg::RST_MAX_VEL;
      lim_acc = tvp_pkg::RST_MAX_ACC;
      step_len = tvp_pkg::RST_STEP;
      moving = 1'b0;
      now_t = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A tick while idle gives nothing; a zero-length move gives one point with the
      // acceleration positive, since its direction counts as negative.
      rows.insert(rows.size(), '{tvp_pkg::CMD_TICK, 32'sd0, 32'sd0, 1'b0, none});
      rows.insert(rows.size(), '{tvp_pkg::CMD_START, 32'sd0, 32'sd0, 1'b0, none});
      rows.insert(rows.size(), '{tvp_pkg::CMD_TICK, 32'sd0, 32'sd0, 1'b1, zero_move});
      rows.insert(rows.size(), '{tvp_pkg::CMD_TICK, 32'sd0, 32'sd0, 1'b0, none});
      // Full-range moves both ways, then a short forward and a short backward move.
      rows.insert(rows.size(),
                  '{tvp_pkg::CMD_START, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, none});
      repeat (3)
         rows.insert(rows.size(), '{tvp_pkg::CMD_TICK, 32'sd0, 32'sd0, 1'b0, none});
      rows.insert(rows.size(),
                  '{tvp_pkg::CMD_START, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, none});
      repeat (3)
         rows.insert(rows.size(), '{tvp_pkg::CMD_TICK, 32'sd0, 32'sd0, 1'b0, none});
      rows.insert(rows.size(), '{tvp_pkg::CMD_START, 32'sd65536, 32'sd98304, 1'b0, none});
      repeat (4)
         rows.insert(rows.size(), '{tvp_pkg::CMD_TICK, 32'sd0, 32'sd0, 1'b0, none});
      // A restart while a move is running drops the old move.
      rows.insert(rows.size(),
                  '{tvp_pkg::CMD_START, -32'sd131072, -32'sd196608, 1'b0, none});
      repeat (5)
         rows.insert(rows.size(), '{tvp_pkg::CMD_TICK, 32'sd0, 32'sd0, 1'b0, none});

      foreach (rows[i]) begin
         row = rows[i];
         send_word(row.command, row.start_pos, row.end_pos, row.typed, row.point, 1'b0);
      end

      items = 0;
      for (int phase = 0; phase < 8; phase++) begin
         drain_block();
         case (phase)
            0: begin
               // Lowest register values: moves never end, so every one is cut short.
               write_reg(tvp_pkg::REG_MAX_VELOCITY, 31'd1);
               write_reg(tvp_pkg::REG_MAX_ACCELERATION, 31'd1);
               write_reg(tvp_pkg::REG_TIME_STEP, 31'd1);
            end
            1: begin
               write_reg(tvp_pkg::REG_MAX_VELOCITY, 31'h7FFF_FFFF);
               write_reg(tvp_pkg::REG_MAX_ACCELERATION, 31'h7FFF_FFFF);
               write_reg(tvp_pkg::REG_TIME_STEP, 31'h7FFF_FFFF);
               write_reg(REG_UNUSED, 31'h5555_5555);
            end
            2: begin
               write_reg(tvp_pkg::REG_MAX_VELOCITY, tvp_pkg::RST_MAX_VEL);
               write_reg(tvp_pkg::REG_MAX_ACCELERATION, tvp_pkg::RST_MAX_ACC);
               write_reg(tvp_pkg::REG_TIME_STEP, 31'd8192);
            end
            default: begin
               write_reg(tvp_pkg::REG_MAX_VELOCITY, 31'($urandom_range(1 << 22, 1 << 12)));
               write_reg(tvp_pkg::REG_MAX_ACCELERATION,
                         31'($urandom_range(1 << 22, 1 << 12)));
               write_reg(tvp_pkg::REG_TIME_STEP, 31'($urandom_range(1 << 17, 1 << 10)));
            end
         endcase
         csr_ch.valid <= 1'b0;
         while (items < (ITEM_TARGET * (phase + 1)) / 8) begin
            quiet = ($urandom_range(7) == 0);
            if ($urandom_range(15) == 0) begin
               // Occasional noise: full-width positions and stray ticks.
               s = $urandom;
               e = $urandom;
            end else begin
               span_bits = $urandom_range(31);
               mag = $urandom & ((32'd1 << span_bits) - 1);
               s = $urandom_range(2_000_000) - 1_000_000;
               e = $urandom_range(1) ? s + $signed(mag) : s - $signed(mag);
            end
            send_word(tvp_pkg::CMD_START, s, e, 1'b0, none, quiet);
            items++;
            ticks = $urandom_range(60, 1);
            for (int k = 0; k < ticks; k++) begin
               send_word(tvp_pkg::CMD_TICK, $urandom, $urandom, 1'b0, none, quiet);
               items++;
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (points_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
rtl/tvp_pkg.sv
rtl/tvp_if.sv
rtl/tvp_mul.sv
rtl/tvp_divsqrt.sv
rtl/trapezoidal_velocity_profile_top.sv
dv/tb_top.sv
